### rtl/core/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Types, codes and lookup functions shared by the power channel controller.
// ----------------------------------------------------------------------------
package pcc_pkg;

   typedef enum logic [1:0] {
      ST_INITIAL   = 2'd0,
      ST_POWER_ON  = 2'd1,
      ST_ALARM     = 2'd2,
      ST_POWER_OFF = 2'd3
   } state_type;

   typedef enum logic [3:0] {
      IND_ALARM       = 4'd0,
      IND_KICKSTAND   = 4'd1,
      IND_UNMOD_ON    = 4'd2,
      IND_MOD_OFF     = 4'd3,
      IND_MOD_Q1      = 4'd4,
      IND_MOD_Q2      = 4'd5,
      IND_MOD_Q3      = 4'd6,
      IND_MOD_Q4      = 4'd7,
      IND_MODE_CHANGE = 4'd8,
      IND_FAULT       = 4'd9
   } ind_type;

   typedef enum logic [2:0] {
      CSR_BUS_OFF_TIMEOUT    = 3'd0,
      CSR_IGNITION_TIMEOUT   = 3'd1,
      CSR_ALARM_MINUTES      = 3'd2,
      CSR_SHORT_PRESS_MIN    = 3'd3,
      CSR_SHORT_PRESS_MAX    = 3'd4,
      CSR_LONG_PRESS         = 3'd5,
      CSR_RESTORED_MODE      = 3'd6,
      CSR_RESTORED_LEVEL     = 3'd7
   } csr_index_type;

   localparam logic [2:0] LED0_OFF       = 3'd0;
   localparam logic [2:0] LED0_ON        = 3'd1;
   localparam logic [2:0] LED0_FLASH_1HZ = 3'd2;
   localparam logic [2:0] LED0_FLASH_4HZ = 3'd3;
   localparam logic [2:0] LED0_BLIPS     = 3'd4;

   localparam logic [2:0] LED1_OFF        = 3'd0;
   localparam logic [2:0] LED1_BLIP1      = 3'd1;
   localparam logic [2:0] LED1_BLIP2      = 3'd2;
   localparam logic [2:0] LED1_BLIP3      = 3'd3;
   localparam logic [2:0] LED1_BLIP4      = 3'd4;
   localparam logic [2:0] LED1_BLIP4_ONCE = 3'd5;

   localparam logic [2:0]  LEVEL_MAX   = 3'd4;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   typedef struct packed {
      logic [15:0] bus_off_timeout;
      logic [15:0] ignition_timeout;
      logic [15:0] alarm_minutes;
      logic [15:0] short_press_min;
      logic [15:0] short_press_max;
      logic [15:0] long_press;
      logic [7:0]  restored_mode;
      logic [7:0]  restored_level;
   } cfg_type;

   typedef struct packed {
      logic [15:0] now_ticks;
      logic [15:0] now_minutes;
      logic        bus_seen;
      logic        chip_fault;
      logic        kickstand_down;
      logic        button_down;
      logic        ambient_dark;
   } req_type;

   typedef struct packed {
      logic [1:0]  fsm_state;
      logic        power_latch;
      logic        switch_enable;
      logic [10:0] ch0_duty;
      logic        ch0_fast;
      logic        ch1_on;
      logic [2:0]  status_led;
      logic [2:0]  level_led;
      logic        led_dim;
      logic        save_now;
      logic        channel_mode;
      logic [2:0]  power_level;
   } rsp_type;

   function automatic ind_type channel_ind(input logic mode, input logic [2:0] level);
      ind_type ind;
      if (mode) begin
         ind = IND_UNMOD_ON;
      end else begin
         case (level)
            3'd1:    ind = IND_MOD_Q1;
            3'd2:    ind = IND_MOD_Q2;
            3'd3:    ind = IND_MOD_Q3;
            3'd4:    ind = IND_MOD_Q4;
            default: ind = IND_MOD_OFF;
         endcase
      end
      return ind;
   endfunction

   function automatic logic [5:0] led_pair(input ind_type ind);
      logic [5:0] pair;
      case (ind)
         IND_ALARM:       pair = {LED0_BLIPS, LED1_OFF};
         IND_KICKSTAND:   pair = {LED0_FLASH_1HZ, LED1_OFF};
         IND_UNMOD_ON:    pair = {LED0_ON, LED1_OFF};
         IND_MOD_OFF:     pair = {LED0_OFF, LED1_OFF};
         IND_MOD_Q1:      pair = {LED0_OFF, LED1_BLIP1};
         IND_MOD_Q2:      pair = {LED0_OFF, LED1_BLIP2};
         IND_MOD_Q3:      pair = {LED0_OFF, LED1_BLIP3};
         IND_MOD_Q4:      pair = {LED0_OFF, LED1_BLIP4};
         IND_MODE_CHANGE: pair = {LED0_OFF, LED1_BLIP4_ONCE};
         IND_FAULT:       pair = {LED0_FLASH_4HZ, LED1_OFF};
         default:         pair = {LED0_OFF, LED1_OFF};
      endcase
      return pair;
   endfunction

endpackage

### rtl/core/pcc_csr.sv
// ----------------------------------------------------------------------------
// pcc_csr
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module pcc_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [2:0]            wr_index,
   input  logic [15:0]           wr_data,
   output pcc_pkg::cfg_type      cfg
);

   pcc_pkg::cfg_type cfg_ff;
   pcc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (pcc_pkg::csr_index_type'(wr_index))
            pcc_pkg::CSR_BUS_OFF_TIMEOUT:    cfg_in.bus_off_timeout    = wr_data;
            pcc_pkg::CSR_IGNITION_TIMEOUT:   cfg_in.ignition_timeout   = wr_data;
            pcc_pkg::CSR_ALARM_MINUTES:      cfg_in.alarm_minutes      = wr_data;
            pcc_pkg::CSR_SHORT_PRESS_MIN:    cfg_in.short_press_min    = wr_data;
            pcc_pkg::CSR_SHORT_PRESS_MAX:    cfg_in.short_press_max    = wr_data;
            pcc_pkg::CSR_LONG_PRESS:         cfg_in.long_press         = wr_data;
            pcc_pkg::CSR_RESTORED_MODE:      cfg_in.restored_mode      = wr_data[7:0];
            pcc_pkg::CSR_RESTORED_LEVEL:     cfg_in.restored_level     = wr_data[7:0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bus_off_timeout    <= 16'd18000;
         cfg_ff.ignition_timeout   <= 16'd100;
         cfg_ff.alarm_minutes      <= 16'd720;
         cfg_ff.short_press_min    <= 16'd5;
         cfg_ff.short_press_max    <= 16'd100;
         cfg_ff.long_press         <= 16'd2000;
         cfg_ff.restored_mode      <= 8'd0;
         cfg_ff.restored_level     <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/pcc_fsm.sv
// ----------------------------------------------------------------------------
// pcc_fsm
// Controller state machine, button classifier and held channel outputs.
// Updates once per transaction and presents the result for that transaction.
// ----------------------------------------------------------------------------
module pcc_fsm #(
   parameter int DUTY_FULL = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  pcc_pkg::req_type      req,
   input  pcc_pkg::cfg_type      cfg,
   output pcc_pkg::rsp_type      rsp
);

   localparam logic [10:0] DUTY_Q1 = 11'((DUTY_FULL / 4) % 2048);
   localparam logic [10:0] DUTY_Q2 = 11'((DUTY_FULL / 2) % 2048);
   localparam logic [10:0] DUTY_Q3 = 11'(((DUTY_FULL * 3) / 4) % 2048);
   localparam logic [10:0] DUTY_Q4 = 11'(DUTY_FULL % 2048);

   function automatic logic [10:0] ch0_duty(input logic mode, input logic [2:0] level);
      logic [10:0] duty;
      if (mode) begin
         duty = DUTY_Q4;
      end else begin
         case (level)
            3'd1:    duty = DUTY_Q1;
            3'd2:    duty = DUTY_Q2;
            3'd3:    duty = DUTY_Q3;
            3'd4:    duty = DUTY_Q4;
            default: duty = 11'd0;
         endcase
      end
      return duty;
   endfunction

   pcc_pkg::state_type fsm_ff, fsm_in;
   logic [15:0]        last_bus_ff, last_bus_in;
   logic [15:0]        press_ff, press_in;
   logic [15:0]        quiet_ff, quiet_in;
   logic               mode_ff, mode_in;
   logic [2:0]         level_ff, level_in;
   logic [15:0]        alarm_start_ff, alarm_start_in;
   pcc_pkg::ind_type   ind_ff, ind_in;
   logic [10:0]        duty_ff, duty_in;
   logic               fast_ff, fast_in;
   logic               ch1_ff, ch1_in;
   logic               sw_ff, sw_in;
   logic               latch_ff, latch_in;
   logic               dim_ff, dim_in;
   logic               powered_ff, powered_in;
   logic               save;

   logic [15:0] bus_time;
   logic [15:0] since;
   logic [15:0] alarm_age;
   logic [15:0] press_inc;
   logic        leave_on;
   logic        alarm_done;
   logic        enter_on;
   logic        entry_mode;
   logic [2:0]  entry_level;
   logic [2:0]  next_level;
   logic        short_hit;
   logic        quiet_ok;
   logic [5:0]  led_bits;

   assign bus_time   = req.bus_seen ? req.now_ticks : last_bus_ff;
   assign since      = req.now_ticks - bus_time;
   assign leave_on   = (since > cfg.bus_off_timeout) ||
                       (req.chip_fault && (since > cfg.ignition_timeout));
   assign alarm_age  = req.now_minutes - alarm_start_ff;
   assign alarm_done = (cfg.alarm_minutes == 16'd0) || (alarm_age > cfg.alarm_minutes);
   assign press_inc  = (press_ff < pcc_pkg::COUNT_MAX) ? press_ff + 16'd1 : press_ff;
   assign quiet_ok   = quiet_ff >= cfg.short_press_min;
   assign short_hit  = !mode_ff && (press_ff >= cfg.short_press_min) &&
                       (press_ff <= cfg.short_press_max) && quiet_ok;
   assign next_level = (level_ff >= pcc_pkg::LEVEL_MAX) ? 3'd0 : level_ff + 3'd1;
   assign entry_mode = powered_ff ? mode_ff :
                       ((cfg.restored_mode < 8'd2) ? cfg.restored_mode[0] : 1'b0);
   assign entry_level = powered_ff ? level_ff :
                        ((cfg.restored_level < 8'd5) ? cfg.restored_level[2:0] : 3'd0);

   always_comb begin
      case (fsm_ff)
         pcc_pkg::ST_INITIAL:   enter_on = 1'b1;
         pcc_pkg::ST_POWER_ON:  enter_on = 1'b0;
         pcc_pkg::ST_ALARM:     enter_on = req.bus_seen;
         pcc_pkg::ST_POWER_OFF: enter_on = req.bus_seen;
         default:               enter_on = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         pcc_pkg::ST_INITIAL: fsm_in = pcc_pkg::ST_POWER_ON;
         pcc_pkg::ST_POWER_ON: begin
            if (leave_on) fsm_in = pcc_pkg::ST_ALARM;
         end
         pcc_pkg::ST_ALARM: begin
            if (req.bus_seen)    fsm_in = pcc_pkg::ST_POWER_ON;
            else if (alarm_done) fsm_in = pcc_pkg::ST_POWER_OFF;
         end
         pcc_pkg::ST_POWER_OFF: begin
            if (req.bus_seen) fsm_in = pcc_pkg::ST_POWER_ON;
         end
         default: fsm_in = fsm_ff;
      endcase
   end

   // outputs and datapath
   always_comb begin
      last_bus_in    = last_bus_ff;
      press_in       = press_ff;
      quiet_in       = quiet_ff;
      mode_in        = mode_ff;
      level_in       = level_ff;
      alarm_start_in = alarm_start_ff;
      ind_in         = ind_ff;
      duty_in        = duty_ff;
      fast_in        = fast_ff;
      ch1_in         = ch1_ff;
      sw_in          = sw_ff;
      latch_in       = latch_ff;
      dim_in         = dim_ff;
      powered_in     = powered_ff;
      save           = 1'b0;
      if (enter_on) begin
         latch_in    = 1'b1;
         sw_in       = 1'b1;
         ch1_in      = 1'b1;
         mode_in     = entry_mode;
         level_in    = entry_level;
         powered_in  = 1'b1;
         duty_in     = ch0_duty(entry_mode, entry_level);
         fast_in     = entry_mode;
         press_in    = 16'd0;
         quiet_in    = 16'd0;
         last_bus_in = req.now_ticks;
      end else if (fsm_ff == pcc_pkg::ST_POWER_ON) begin
         dim_in      = req.ambient_dark;
         last_bus_in = bus_time;
         if (leave_on) begin
            duty_in        = 11'd0;
            fast_in        = 1'b1;
            ch1_in         = 1'b0;
            sw_in          = 1'b0;
            save           = 1'b1;
            ind_in         = pcc_pkg::IND_ALARM;
            dim_in         = 1'b0;
            alarm_start_in = req.now_minutes;
         end else if (req.chip_fault) begin
            ind_in = pcc_pkg::IND_FAULT;
         end else if (req.kickstand_down && (since < cfg.ignition_timeout)) begin
            ind_in   = pcc_pkg::IND_KICKSTAND;
            press_in = 16'd0;
         end else if (req.button_down) begin
            press_in = press_inc;
            if ((press_inc == cfg.long_press) && quiet_ok) begin
               mode_in = !mode_ff;
               ind_in  = pcc_pkg::IND_MODE_CHANGE;
               duty_in = ch0_duty(!mode_ff, level_ff);
               fast_in = !mode_ff;
            end
         end else begin
            if (short_hit) begin
               level_in = next_level;
               duty_in  = ch0_duty(1'b0, next_level);
               fast_in  = 1'b0;
            end
            if (press_ff != 16'd0) begin
               press_in = 16'd0;
               quiet_in = 16'd0;
            end else if (quiet_ff < pcc_pkg::COUNT_MAX) begin
               quiet_in = quiet_ff + 16'd1;
            end
            ind_in = pcc_pkg::channel_ind(mode_ff, short_hit ? next_level : level_ff);
         end
      end else if ((fsm_ff == pcc_pkg::ST_ALARM) && alarm_done) begin
         latch_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff         <= pcc_pkg::ST_INITIAL;
         last_bus_ff    <= 16'd0;
         press_ff       <= 16'd0;
         quiet_ff       <= 16'd0;
         mode_ff        <= 1'b0;
         level_ff       <= 3'd0;
         alarm_start_ff <= 16'd0;
         ind_ff         <= pcc_pkg::IND_MOD_OFF;
         duty_ff        <= 11'd0;
         fast_ff        <= 1'b0;
         ch1_ff         <= 1'b0;
         sw_ff          <= 1'b0;
         latch_ff       <= 1'b0;
         dim_ff         <= 1'b0;
         powered_ff     <= 1'b0;
      end else if (step) begin
         fsm_ff         <= fsm_in;
         last_bus_ff    <= last_bus_in;
         press_ff       <= press_in;
         quiet_ff       <= quiet_in;
         mode_ff        <= mode_in;
         level_ff       <= level_in;
         alarm_start_ff <= alarm_start_in;
         ind_ff         <= ind_in;
         duty_ff        <= duty_in;
         fast_ff        <= fast_in;
         ch1_ff         <= ch1_in;
         sw_ff          <= sw_in;
         latch_ff       <= latch_in;
         dim_ff         <= dim_in;
         powered_ff     <= powered_in;
      end
   end

   assign led_bits = pcc_pkg::led_pair(ind_in);

   always_comb begin
      rsp.fsm_state     = fsm_in;
      rsp.power_latch   = latch_in;
      rsp.switch_enable = sw_in;
      rsp.ch0_duty      = duty_in;
      rsp.ch0_fast      = fast_in;
      rsp.ch1_on        = ch1_in;
      rsp.status_led    = led_bits[5:3];
      rsp.level_led     = led_bits[2:0];
      rsp.led_dim       = dim_in;
      rsp.save_now      = save;
      rsp.channel_mode  = mode_in;
      rsp.power_level   = level_in;
   end

endmodule

### rtl/core/power_channel_controller_fsm_core.sv
// ----------------------------------------------------------------------------
// power_channel_controller_fsm_core
// Power channel controller: one timer tick in, one control result out.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   tick, minute, bus and switch flags
//   rsp      out        rsp_valid/rsp_stall   state, channel, led and save outputs
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// One transaction per cycle while results are not stalled; a request is
// registered in the input register, then its result in the result register.
// The state update happens as a request moves from the input register to the
// result register, so all per-tick work is one pass of compare logic.
// Synchronous reset restores register defaults and the initial state.
// A stalled result holds the pipe; the input register keeps accepting while
// it is empty or the result register is free or being drained.
// ----------------------------------------------------------------------------
module power_channel_controller_fsm_core #(
   parameter int DUTY_FULL = 1024
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_now_ticks,
   input  logic [15:0] req_now_minutes,
   input  logic        req_bus_seen,
   input  logic        req_chip_fault,
   input  logic        req_kickstand_down,
   input  logic        req_button_down,
   input  logic        req_ambient_dark,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_fsm_state,
   output logic        rsp_power_latch,
   output logic        rsp_switch_enable,
   output logic [10:0] rsp_ch0_duty,
   output logic        rsp_ch0_fast,
   output logic        rsp_ch1_on,
   output logic [2:0]  rsp_status_led,
   output logic [2:0]  rsp_level_led,
   output logic        rsp_led_dim,
   output logic        rsp_save_now,
   output logic        rsp_channel_mode,
   output logic [2:0]  rsp_power_level,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   pcc_pkg::cfg_type cfg;
   pcc_pkg::req_type req_ff, req_in;
   pcc_pkg::rsp_type rsp_ff, step_rsp;
   logic             req_valid_ff, req_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             advance;
   logic             accept;
   logic             step;

   assign csr_ready = 1'b1;

   pcc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      req_in.now_ticks      = req_now_ticks;
      req_in.now_minutes    = req_now_minutes;
      req_in.bus_seen       = req_bus_seen;
      req_in.chip_fault     = req_chip_fault;
      req_in.kickstand_down = req_kickstand_down;
      req_in.button_down    = req_button_down;
      req_in.ambient_dark   = req_ambient_dark;
   end

   assign req_valid_in = accept ? 1'b1 : (step ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (advance ? 1'b0 : rsp_valid_ff);

   pcc_fsm #(
      .DUTY_FULL (DUTY_FULL)
   ) u_fsm (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_in;
      if (step)   rsp_ff <= step_rsp;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fsm_state     = rsp_ff.fsm_state;
   assign rsp_power_latch   = rsp_ff.power_latch;
   assign rsp_switch_enable = rsp_ff.switch_enable;
   assign rsp_ch0_duty      = rsp_ff.ch0_duty;
   assign rsp_ch0_fast      = rsp_ff.ch0_fast;
   assign rsp_ch1_on        = rsp_ff.ch1_on;
   assign rsp_status_led    = rsp_ff.status_led;
   assign rsp_level_led     = rsp_ff.level_led;
   assign rsp_led_dim       = rsp_ff.led_dim;
   assign rsp_save_now      = rsp_ff.save_now;
   assign rsp_channel_mode  = rsp_ff.channel_mode;
   assign rsp_power_level   = rsp_ff.power_level;

`ifndef NO_ASSERTIONS
   // save strobe only on the transaction that leaves power on
   a_save_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_save_now |-> rsp_fsm_state == pcc_pkg::ST_ALARM)
      else $error("save strobe outside alarm entry");

   // switch is enabled only while powered on
   a_switch_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switch_enable |-> rsp_fsm_state == pcc_pkg::ST_POWER_ON)
      else $error("switch enabled outside power on");

   // supply latch drops only in power off
   a_latch_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_power_latch |-> rsp_fsm_state == pcc_pkg::ST_POWER_OFF)
      else $error("latch released outside power off");

   // level stays within quarters of full
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_power_level <= pcc_pkg::LEVEL_MAX)
      else $error("power level out of range");
`endif

endmodule

### sim/pcc_tick_checker.sv
// ----------------------------------------------------------------------------
// pcc_tick_checker
// Watches the tick, result and register channels of the power channel
// controller. It keeps its own copy of the controller state and settings,
// works out the outputs due for every accepted tick, and compares each
// accepted result field by field with the oldest outputs still due.
// ----------------------------------------------------------------------------
module pcc_tick_checker #(
   parameter int FULL_SCALE = 1024
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_now_ticks,
   input  logic [15:0] req_now_minutes,
   input  logic        req_bus_seen,
   input  logic        req_chip_fault,
   input  logic        req_kickstand_down,
   input  logic        req_button_down,
   input  logic        req_ambient_dark,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_fsm_state,
   input  logic        rsp_power_latch,
   input  logic        rsp_switch_enable,
   input  logic [10:0] rsp_ch0_duty,
   input  logic        rsp_ch0_fast,
   input  logic        rsp_ch1_on,
   input  logic [2:0]  rsp_status_led,
   input  logic [2:0]  rsp_level_led,
   input  logic        rsp_led_dim,
   input  logic        rsp_save_now,
   input  logic        rsp_channel_mode,
   input  logic [2:0]  rsp_power_level,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,

   output int          mismatch_count,
   output int          results_due
);

   pcc_pkg::rsp_type   due_results[$];

   pcc_pkg::state_type st;
   pcc_pkg::ind_type   ind_q;
   logic [15:0] last_bus;
   logic [15:0] press_cnt;
   logic [15:0] quiet_cnt;
   logic [15:0] alarm_t0;
   logic        mode_q;
   logic [2:0]  level_q;
   logic [10:0] duty_q;
   logic        fast_q;
   logic        ch1_q;
   logic        sw_q;
   logic        latch_q;
   logic        dim_q;
   bit          restored_done;

   logic [15:0] off_delay;
   logic [15:0] ign_delay;
   logic [15:0] alarm_len;
   logic [15:0] press_min;
   logic [15:0] press_max;
   logic [15:0] press_long;
   logic [7:0]  rest_mode;
   logic [7:0]  rest_level;

   int          mismatches = 0;

   assign mismatch_count = mismatches;

   task automatic load_ch0();
      int d;
      if (mode_q) begin
         d = FULL_SCALE;
      end else begin
         case (level_q)
            3'd1:    d = FULL_SCALE / 4;
            3'd2:    d = FULL_SCALE / 2;
            3'd3:    d = FULL_SCALE * 3 / 4;
            3'd4:    d = FULL_SCALE;
            default: d = 0;
         endcase
      end
      duty_q = d[10:0];
      fast_q = mode_q;
   endtask

   task automatic power_up(input logic [15:0] t);
      st = pcc_pkg::ST_POWER_ON;
      latch_q = 1'b1;
      // saved mode and level only apply on the very first power up
      if (!restored_done) begin
         mode_q = (rest_mode < 8'd2) ? rest_mode[0] : 1'b0;
         level_q = (rest_level < 8'd5) ? rest_level[2:0] : 3'd0;
         restored_done = 1'b1;
      end
      sw_q = 1'b1;
      load_ch0();
      ch1_q = 1'b1;
      press_cnt = '0;
      quiet_cnt = '0;
      last_bus = t;
   endtask

   task automatic predict_tick(input logic [15:0] t, input logic [15:0] m,
                               input logic bus, input logic fault, input logic kick,
                               input logic btn, input logic dark,
                               output pcc_pkg::rsp_type r);
      logic [15:0] since;
      logic [15:0] elapsed;
      logic        save;
      save = 1'b0;
      case (st)
         pcc_pkg::ST_INITIAL: begin
            power_up(t);
         end
         pcc_pkg::ST_POWER_ON: begin
            dim_q = dark;
            if (bus) last_bus = t;
            since = t - last_bus;
            if (since > off_delay || (fault && since > ign_delay)) begin
               duty_q = '0;
               fast_q = 1'b1;
               ch1_q = 1'b0;
               sw_q = 1'b0;
               save = 1'b1;
               st = pcc_pkg::ST_ALARM;
               ind_q = pcc_pkg::IND_ALARM;
               dim_q = 1'b0;
               alarm_t0 = m;
            end else if (fault) begin
               ind_q = pcc_pkg::IND_FAULT;
            end else if (kick && since < ign_delay) begin
               ind_q = pcc_pkg::IND_KICKSTAND;
               press_cnt = '0;
            end else if (btn) begin
               if (press_cnt != pcc_pkg::COUNT_MAX) press_cnt = press_cnt + 16'd1;
               if (press_cnt == press_long && quiet_cnt >= press_min) begin
                  mode_q = ~mode_q;
                  ind_q = pcc_pkg::IND_MODE_CHANGE;
                  load_ch0();
               end
            end else begin
               if (!mode_q && press_cnt >= press_min && press_cnt <= press_max &&
                   quiet_cnt >= press_min) begin
                  level_q = (level_q >= pcc_pkg::LEVEL_MAX) ? 3'd0 : level_q + 3'd1;
                  load_ch0();
               end
               if (press_cnt != 16'd0) begin
                  press_cnt = '0;
                  quiet_cnt = '0;
               end else if (quiet_cnt != pcc_pkg::COUNT_MAX) begin
                  quiet_cnt = quiet_cnt + 16'd1;
               end
               if (mode_q) begin
                  ind_q = pcc_pkg::IND_UNMOD_ON;
               end else if (level_q == 3'd0 || level_q > pcc_pkg::LEVEL_MAX) begin
                  ind_q = pcc_pkg::IND_MOD_OFF;
               end else begin
                  ind_q = pcc_pkg::ind_type'(pcc_pkg::IND_MOD_Q1 + level_q - 3'd1);
               end
            end
         end
         pcc_pkg::ST_ALARM: begin
            elapsed = m - alarm_t0;
            if (bus) begin
               power_up(t);
            end else if (alarm_len == 16'd0 || elapsed > alarm_len) begin
               st = pcc_pkg::ST_POWER_OFF;
               latch_q = 1'b0;
            end
         end
         default: begin
            if (bus) power_up(t);
         end
      endcase

      r.fsm_state = st;
      r.power_latch = latch_q;
      r.switch_enable = sw_q;
      r.ch0_duty = duty_q;
      r.ch0_fast = fast_q;
      r.ch1_on = ch1_q;
      r.status_led = pcc_pkg::LED0_OFF;
      r.level_led = pcc_pkg::LED1_OFF;
      case (ind_q)
         pcc_pkg::IND_ALARM:       r.status_led = pcc_pkg::LED0_BLIPS;
         pcc_pkg::IND_KICKSTAND:   r.status_led = pcc_pkg::LED0_FLASH_1HZ;
         pcc_pkg::IND_UNMOD_ON:    r.status_led = pcc_pkg::LED0_ON;
         pcc_pkg::IND_FAULT:       r.status_led = pcc_pkg::LED0_FLASH_4HZ;
         pcc_pkg::IND_MOD_Q1:      r.level_led = pcc_pkg::LED1_BLIP1;
         pcc_pkg::IND_MOD_Q2:      r.level_led = pcc_pkg::LED1_BLIP2;
         pcc_pkg::IND_MOD_Q3:      r.level_led = pcc_pkg::LED1_BLIP3;
         pcc_pkg::IND_MOD_Q4:      r.level_led = pcc_pkg::LED1_BLIP4;
         pcc_pkg::IND_MODE_CHANGE: r.level_led = pcc_pkg::LED1_BLIP4_ONCE;
         default: ;
      endcase
      r.led_dim = dim_q;
      r.save_now = save;
      r.channel_mode = mode_q;
      r.power_level = level_q;
   endtask

   task automatic cmp(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      pcc_pkg::rsp_type want;
      if (reset) begin
         st = pcc_pkg::ST_INITIAL;
         ind_q = pcc_pkg::IND_MOD_OFF;
         last_bus = '0;
         press_cnt = '0;
         quiet_cnt = '0;
         alarm_t0 = '0;
         mode_q = 1'b0;
         level_q = '0;
         duty_q = '0;
         fast_q = 1'b0;
         ch1_q = 1'b0;
         sw_q = 1'b0;
         latch_q = 1'b0;
         dim_q = 1'b0;
         restored_done = 1'b0;
         off_delay = 16'd18000;
         ign_delay = 16'd100;
         alarm_len = 16'd720;
         press_min = 16'd5;
         press_max = 16'd100;
         press_long = 16'd2000;
         rest_mode = '0;
         rest_level = '0;
         due_results.delete();
         results_due <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (pcc_pkg::csr_index_type'(csr_index))
               pcc_pkg::CSR_BUS_OFF_TIMEOUT:  off_delay = csr_data;
               pcc_pkg::CSR_IGNITION_TIMEOUT: ign_delay = csr_data;
               pcc_pkg::CSR_ALARM_MINUTES:    alarm_len = csr_data;
               pcc_pkg::CSR_SHORT_PRESS_MIN:  press_min = csr_data;
               pcc_pkg::CSR_SHORT_PRESS_MAX:  press_max = csr_data;
               pcc_pkg::CSR_LONG_PRESS:       press_long = csr_data;
               pcc_pkg::CSR_RESTORED_MODE:    rest_mode = csr_data[7:0];
               pcc_pkg::CSR_RESTORED_LEVEL:   rest_level = csr_data[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("result with no transaction pending: fsm_state %0d", rsp_fsm_state);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               cmp("fsm_state", want.fsm_state, rsp_fsm_state);
               cmp("power_latch", want.power_latch, rsp_power_latch);
               cmp("switch_enable", want.switch_enable, rsp_switch_enable);
               cmp("ch0_duty", want.ch0_duty, rsp_ch0_duty);
               cmp("ch0_fast", want.ch0_fast, rsp_ch0_fast);
               cmp("ch1_on", want.ch1_on, rsp_ch1_on);
               cmp("status_led", want.status_led, rsp_status_led);
               cmp("level_led", want.level_led, rsp_level_led);
               cmp("led_dim", want.led_dim, rsp_led_dim);
               cmp("save_now", want.save_now, rsp_save_now);
               cmp("channel_mode", want.channel_mode, rsp_channel_mode);
               cmp("power_level", want.power_level, rsp_power_level);
            end
         end
         if (req_valid && !req_stall) begin
            predict_tick(req_now_ticks, req_now_minutes, req_bus_seen, req_chip_fault,
                         req_kickstand_down, req_button_down, req_ambient_dark, want);
            due_results.push_back(want);
         end
         results_due <= due_results.size();
      end
   end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for the power channel controller. Drives timer ticks through a
// directed opening and then phases of random button, bus silence, fault,
// kickstand and noise sequences under changing register settings, with
// random stalls on both channels. A checker beside the block predicts and
// compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int FULL_SCALE     = 1024;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 128;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_now_ticks = '0;
   logic [15:0] req_now_minutes = '0;
   logic        req_bus_seen = 1'b0;
   logic        req_chip_fault = 1'b0;
   logic        req_kickstand_down = 1'b0;
   logic        req_button_down = 1'b0;
   logic        req_ambient_dark = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_fsm_state;
   logic        rsp_power_latch;
   logic        rsp_switch_enable;
   logic [10:0] rsp_ch0_duty;
   logic        rsp_ch0_fast;
   logic        rsp_ch1_on;
   logic [2:0]  rsp_status_led;
   logic [2:0]  rsp_level_led;
   logic        rsp_led_dim;
   logic        rsp_save_now;
   logic        rsp_channel_mode;
   logic [2:0]  rsp_power_level;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   int          mismatch_count;
   int          results_due;

   bit          tx_idle = 1'b1;
   bit          rx_idle = 1'b1;
   bit          hold_rsp = 1'b0;
   int          idle_cycles = 0;
   int          phase_items = 0;
   logic [15:0] tick_now = '0;
   logic [15:0] minute_now = '0;
   logic [15:0] cfg_off, cfg_ign, cfg_pmin, cfg_pmax, cfg_long;

   power_channel_controller_fsm_core #(.DUTY_FULL(FULL_SCALE)) uut (.*);

   pcc_tick_checker #(.FULL_SCALE(FULL_SCALE)) u_checker (.*);

   always #4 clock = ~clock;

   function automatic int pick_run();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 8);
      return $urandom_range(15, 50);
   endfunction

   task automatic send_tick(input logic [15:0] t, input logic [15:0] m, input logic bus,
                            input logic fault, input logic kick, input logic btn,
                            input logic dark);
      int gap;
      req_valid <= 1'b1;
      req_now_ticks <= t;
      req_now_minutes <= m;
      req_bus_seen <= bus;
      req_chip_fault <= fault;
      req_kickstand_down <= kick;
      req_button_down <= btn;
      req_ambient_dark <= dark;
      do @(posedge clock); while (req_stall);
      gap = (tx_idle && $urandom_range(0, 2) == 0) ? pick_run() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic tick_item(input logic bus, input logic fault, input logic kick,
                            input logic btn);
      if ($urandom_range(0, 49) == 0) tick_now = 16'($urandom);
      else tick_now = tick_now + 16'd1;
      if ($urandom_range(0, 99) == 0) minute_now = 16'($urandom);
      else if ($urandom_range(0, 1) == 1) minute_now = minute_now + 16'd1;
      send_tick(tick_now, minute_now, bus, fault, kick, btn, 1'($urandom_range(0, 1)));
      phase_items++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input pcc_pkg::csr_index_type idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(input logic [15:0] off, input logic [15:0] ign,
                                input logic [15:0] alarm, input logic [15:0] pmin,
                                input logic [15:0] pmax, input logic [15:0] plong,
                                input logic [15:0] rmode, input logic [15:0] rlevel);
      csr_write(pcc_pkg::CSR_BUS_OFF_TIMEOUT, off);
      csr_write(pcc_pkg::CSR_IGNITION_TIMEOUT, ign);
      csr_write(pcc_pkg::CSR_ALARM_MINUTES, alarm);
      csr_write(pcc_pkg::CSR_SHORT_PRESS_MIN, pmin);
      csr_write(pcc_pkg::CSR_SHORT_PRESS_MAX, pmax);
      csr_write(pcc_pkg::CSR_LONG_PRESS, plong);
      csr_write(pcc_pkg::CSR_RESTORED_MODE, rmode);
      csr_write(pcc_pkg::CSR_RESTORED_LEVEL, rlevel);
      csr_valid <= 1'b0;
      cfg_off = off;
      cfg_ign = ign;
      cfg_pmin = pmin;
      cfg_pmax = pmax;
      cfg_long = plong;
   endtask

   // result side back pressure
   initial begin
      int len;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!rx_idle) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            len = pick_run();
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat (len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0]  rm, rl;
      logic [15:0] off, ign, alarm, pmin, pmax, plong;
      int          q, p, k, j;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // saved mode and level only count before the first tick
      rm = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
      rl = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      load_settings(16'd6, 16'd2, 16'd0, 16'd1, 16'd3, 16'd4,
                    {8'($urandom), rm}, {8'($urandom), rl});

      send_tick(16'hFFFE, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
      send_tick(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(16'd1, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
      send_tick(16'd2, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
      send_tick(16'd3, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(16'd4, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(16'd5, 16'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
      send_tick(16'd6, 16'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      send_tick(16'd7, 16'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
      send_tick(16'd8, 16'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      send_tick(16'd9, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(16'd10, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      send_tick(16'd13, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      send_tick(16'd14, 16'd5, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      send_tick(16'd15, 16'd5, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(16'd16, 16'd6, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(16'd30, 16'd6, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(16'd31, 16'd7, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(16'd32, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      send_tick(16'd40, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(16'd41, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      send_tick(16'hFFFF, 16'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      tick_now = 16'hFFFF;
      minute_now = 16'd1;

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: load_settings('0, '0, '0, '0, '0, '0,
                             {8'($urandom), 8'h00}, {8'($urandom), 8'h00});
            1: load_settings('1, '1, '1, '1, '1, '1,
                             {8'($urandom), 8'hFF}, {8'($urandom), 8'hFF});
            default: begin
               off = 16'($urandom_range(2, 60));
               ign = 16'($urandom_range(0, 20));
               alarm = 16'($urandom_range(0, 8));
               pmin = 16'($urandom_range(0, 4));
               pmax = pmin + 16'($urandom_range(0, 8));
               plong = 16'($urandom_range(1, 30));
               if ($urandom_range(0, 4) == 0) begin
                  case ($urandom_range(0, 5))
                     0: off = 16'($urandom);
                     1: ign = 16'($urandom);
                     2: alarm = 16'($urandom);
                     3: pmin = 16'($urandom);
                     4: pmax = 16'($urandom);
                     default: plong = 16'($urandom);
                  endcase
               end
               load_settings(off, ign, alarm, pmin, pmax, plong, 16'($urandom), 16'($urandom));
            end
         endcase
         tx_idle = (ph % 4 != 1);
         rx_idle = (ph % 4 != 2);
         if (ph == 3) hold_rsp = 1'b1;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  // quiet time, a press of chosen length, then a release
                  q = $urandom_range(0, (cfg_pmin < 6) ? cfg_pmin + 2 : 8);
                  for (j = 0; j < q; j++) begin
                     tick_item($urandom_range(0, 9) != 0, 1'b0, 1'b0, 1'b0);
                  end
                  case ($urandom_range(0, 2))
                     0: p = (cfg_pmin <= cfg_pmax && cfg_pmax < 40) ?
                            $urandom_range(cfg_pmin, cfg_pmax) : $urandom_range(1, 12);
                     1: p = (cfg_long < 60) ? cfg_long + $urandom_range(0, 2) :
                            $urandom_range(1, 12);
                     default: p = $urandom_range(1, 12);
                  endcase
                  for (j = 0; j < p; j++) begin
                     tick_item($urandom_range(0, 9) != 0, 1'b0, $urandom_range(0, 19) == 0,
                               1'b1);
                  end
                  tick_item($urandom_range(0, 9) != 0, 1'b0, 1'b0, 1'b0);
               end
               4, 5: begin
                  // bus goes quiet (long enough to time out when the timeout is short), alarm runs, bus returns
                  p = (cfg_off < 70) ? cfg_off + $urandom_range(1, 3) : $urandom_range(5, 70);
                  for (j = 0; j < p; j++) begin
                     tick_item(1'b0, 1'b0, $urandom_range(0, 9) == 0,
                               $urandom_range(0, 3) == 0);
                  end
                  k = $urandom_range(0, 15);
                  for (j = 0; j < k; j++) tick_item(1'b0, 1'b0, 1'b0, 1'b0);
                  tick_item(1'b1, 1'b0, 1'b0, 1'b0);
               end
               6: begin
                  k = (cfg_ign < 25) ? cfg_ign + $urandom_range(0, 3) : $urandom_range(1, 25);
                  for (j = 0; j < k; j++) begin
                     tick_item($urandom_range(0, 3) == 0, 1'b1, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                  end
                  tick_item(1'b1, 1'b0, 1'b0, 1'b0);
               end
               7: begin
                  k = $urandom_range(1, 10);
                  for (j = 0; j < k; j++) begin
                     tick_item(1'($urandom_range(0, 1)), 1'b0, 1'b1,
                               1'($urandom_range(0, 1)));
                  end
               end
               8: begin
                  k = $urandom_range(1, 6);
                  for (j = 0; j < k; j++) begin
                     tick_now = 16'($urandom);
                     minute_now = 16'($urandom);
                     send_tick(tick_now, minute_now, 1'($urandom), 1'($urandom), 1'($urandom),
                               1'($urandom), 1'($urandom));
                     phase_items++;
                  end
               end
               default: begin
                  if ($urandom_range(0, 1) == 1) drain();
                  else tick_item(1'b1, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
               end
            endcase
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
